FILE: sv/twcs_pkg.sv
// shared constants and types for the textured wall column setup pipeline
// no dependencies
`default_nettype none

package twcs_pkg;

    localparam int TEX_ROWS = 30;
    // quotient bits of the texture step divide, (TEX_ROWS << 16) < 2^21
    localparam int STEP_QW = 21;
    localparam logic [STEP_QW-1:0] STEP_NUM = STEP_QW'(TEX_ROWS * 65536);
    localparam int HEIGHT_QW = 16;
    localparam int COL_W = 8;

    typedef struct packed {
        logic [31:0]      perp;
        logic [COL_W-1:0] col;
    } t_tex_res;

endpackage

`default_nettype wire

FILE: sv/twcs_div.sv
// pipelined restoring divider, one quotient bit per register stage
// carries a sideband word alongside; uses no package items
`default_nettype none

module twcs_div #(
    parameter int DW = 32,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_num,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic          r_vld  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_num  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          s_vld;
        logic [DW-1:0] s_den;
        logic [DW-1:0] s_rem;
        logic [QW-1:0] s_num;
        logic [QW-1:0] s_quo;
        logic [SW-1:0] s_side;
        logic [DW:0]   w_try;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_den  = i_den;
            assign s_rem  = i_rem;
            assign s_num  = i_num;
            assign s_quo  = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_den  = r_den[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_num  = r_num[k-1];
            assign s_quo  = r_quo[k-1];
            assign s_side = r_side[k-1];
        end

        // shift in the next numerator bit and try the subtract
        assign w_try  = {s_rem, s_num[QW-1]};
        assign w_ge   = (w_try >= {1'b0, s_den});
        assign w_diff = w_try - {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[k]  <= s_den;
            r_rem[k]  <= w_ge ? w_diff[DW-1:0] : w_try[DW-1:0];
            r_num[k]  <= {s_num[QW-2:0], 1'b0};
            r_quo[k]  <= {s_quo[QW-2:0], w_ge};
            r_side[k] <= s_side;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

FILE: sv/twcs_tex.sv
// texture column unit: wall hit fraction, scale to texture width, mirror
// three register stages; uses twcs_pkg
`default_nettype none

module twcs_tex #(
    parameter int TEX_SIZE = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_perp,
    input  wire logic        i_side,
    input  wire logic [31:0] i_rdx,
    input  wire logic [31:0] i_rdy,
    input  wire logic [31:0] i_px,
    input  wire logic [31:0] i_py,
    output logic             o_valid,
    output twcs_pkg::t_tex_res o_res
);

    logic [31:0] w_dir;
    logic [31:0] w_pos;
    logic [31:0] w_prod;
    logic        w_mir;

    logic        r_a_vld, r_b_vld, r_c_vld;
    logic [31:0] r_a_prod, r_a_pos, r_a_perp;
    logic        r_a_mir;
    logic [31:0] r_b_frac, r_b_perp;
    logic        r_b_mir;
    logic [twcs_pkg::COL_W-1:0] r_c_col;
    logic [31:0] r_c_perp;

    logic [40:0] w_scaled;
    logic [twcs_pkg::COL_W-1:0] w_col;

    assign w_dir  = i_side ? i_rdx : i_rdy;
    assign w_pos  = i_side ? i_px : i_py;
    // only the low word of the signed product reaches the fraction
    assign w_prod = i_perp * w_dir;
    assign w_mir  = (!i_side && !i_rdx[31] && (i_rdx != 32'h0)) || (i_side && i_rdy[31]);

    assign w_scaled = {9'h0, r_b_frac} * 41'(TEX_SIZE);
    assign w_col    = w_scaled[32 +: twcs_pkg::COL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_prod <= w_prod;
        r_a_pos  <= {w_pos[15:0], 16'h0};
        r_a_perp <= i_perp;
        r_a_mir  <= w_mir;
        r_b_frac <= r_a_prod + r_a_pos;
        r_b_perp <= r_a_perp;
        r_b_mir  <= r_a_mir;
        r_c_col  <= r_b_mir ? twcs_pkg::COL_W'(TEX_SIZE - 1) - w_col : w_col;
        r_c_perp <= r_b_perp;
    end

    assign o_valid    = r_c_vld;
    assign o_res.perp = r_c_perp;
    assign o_res.col  = r_c_col;

endmodule

`default_nettype wire

FILE: sv/textured_wall_column_setup.sv
// pipeline: 43 register stages from the start input to the o_valid strobe
// throughput: one item per cycle, busy stays low; set by two pipelined dividers,
// 16 stages for the slice height and 21 stages for the texture step
// reset: synchronous active low, clears every stage valid bit, no result after it
// depends on twcs_pkg, twcs_tex, twcs_div
`default_nettype none

module textured_wall_column_setup #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int TEX_SIZE      = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [31:0]        i_perp_dist,
    input  wire logic               i_hit_side,
    input  wire logic signed [31:0] i_ray_dir_x,
    input  wire logic signed [31:0] i_ray_dir_y,
    input  wire logic [31:0]        i_player_x,
    input  wire logic [31:0]        i_player_y,
    output logic                    o_valid,
    output logic [15:0]             o_slice_height,
    output logic [8:0]              o_draw_start,
    output logic [8:0]              o_draw_end,
    output logic [4:0]              o_tex_column,
    output logic [31:0]             o_tex_step,
    output logic [20:0]             o_tex_start
);

    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int HS = SCREEN_HEIGHT / 2;
    localparam int CW = twcs_pkg::COL_W;

    typedef struct packed {
        logic          sat;
        logic [CW-1:0] col;
    } t_h_side;

    typedef struct packed {
        logic [15:0]   h;
        logic [RW-1:0] row0;
        logic [RW-1:0] row1;
        logic [15:0]   off;
        logic [CW-1:0] col;
    } t_row_side;

    // input register
    logic        r_in_vld;
    logic [31:0] r_perp, r_rdx, r_rdy, r_px, r_py;
    logic        r_side;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_perp <= i_perp_dist;
        r_side <= i_hit_side;
        r_rdx  <= i_ray_dir_x;
        r_rdy  <= i_ray_dir_y;
        r_px   <= i_player_x;
        r_py   <= i_player_y;
    end

    // texture column
    logic               w_tex_vld;
    twcs_pkg::t_tex_res w_tex;

    twcs_tex #(.TEX_SIZE(TEX_SIZE)) u_tex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .i_perp  (r_perp),
        .i_side  (r_side),
        .i_rdx   (r_rdx),
        .i_rdy   (r_rdy),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_valid (w_tex_vld),
        .o_res   (w_tex)
    );

    // slice height divide; quotient overflows 16 bits when perp <= screen height
    t_h_side     w_h_in, w_h_out;
    logic        w_d1_vld;
    logic [15:0] w_d1_quo;

    assign w_h_in.sat = (w_tex.perp <= 32'(SCREEN_HEIGHT));
    assign w_h_in.col = w_tex.col;

    twcs_div #(.DW(32), .QW(twcs_pkg::HEIGHT_QW), .SW($bits(t_h_side))) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tex_vld),
        .i_den   (w_tex.perp),
        .i_rem   (32'(SCREEN_HEIGHT)),
        .i_num   (16'h0),
        .i_side  (w_h_in),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_h_out)
    );

    logic          r_h_vld;
    logic [15:0]   r_h;
    logic [CW-1:0] r_h_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h     <= w_h_out.sat ? 16'hFFFF : w_d1_quo;
        r_h_col <= w_h_out.col;
    end

    // draw rows and the clamped-off part of the slice
    logic [15:0] w_hh;
    logic        w_over;
    logic [16:0] w_sum;
    t_row_side   w_row_in, w_row_out;

    assign w_hh   = r_h >> 1;
    assign w_over = (w_hh > 16'(HS));
    assign w_sum  = {1'b0, w_hh} + 17'(HS);

    assign w_row_in.h    = r_h;
    assign w_row_in.row0 = w_over ? '0 : RW'(16'(HS) - w_hh);
    assign w_row_in.row1 = (w_sum >= 17'(SCREEN_HEIGHT)) ? RW'(SCREEN_HEIGHT - 1) : RW'(w_sum);
    assign w_row_in.off  = w_over ? (w_hh - 16'(HS)) : 16'h0;
    assign w_row_in.col  = r_h_col;

    // texture step divide
    logic                         w_d2_vld;
    logic [twcs_pkg::STEP_QW-1:0] w_d2_quo;

    twcs_div #(.DW(16), .QW(twcs_pkg::STEP_QW), .SW($bits(t_row_side))) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_h_vld),
        .i_den   (r_h),
        .i_rem   (16'h0),
        .i_num   (twcs_pkg::STEP_NUM),
        .i_side  (w_row_in),
        .o_valid (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_side  (w_row_out)
    );

    // output register
    logic [36:0]   w_tprod;
    logic          r_o_vld;
    logic [15:0]   r_o_h;
    logic [RW-1:0] r_o_row0, r_o_row1;
    logic [CW-1:0] r_o_col;
    logic [31:0]   r_o_step;
    logic [20:0]   r_o_tstart;
    logic [31:0]   w_row0_32, w_row1_32, w_col_32;

    // offset is zero for a zero height, so the product is zero there too
    assign w_tprod = {21'h0, w_row_out.off} * {16'h0, w_d2_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_h      <= w_row_out.h;
        r_o_row0   <= w_row_out.row0;
        r_o_row1   <= w_row_out.row1;
        r_o_col    <= w_row_out.col;
        r_o_step   <= (w_row_out.h == 16'h0) ? 32'hFFFF_FFFF : 32'(w_d2_quo);
        r_o_tstart <= w_tprod[20:0];
    end

    assign w_row0_32 = 32'(r_o_row0);
    assign w_row1_32 = 32'(r_o_row1);
    assign w_col_32  = 32'(r_o_col);

    assign o_valid        = r_o_vld;
    assign o_slice_height = r_o_h;
    assign o_draw_start   = w_row0_32[8:0];
    assign o_draw_end     = w_row1_32[8:0];
    assign o_tex_column   = w_col_32[4:0];
    assign o_tex_step     = r_o_step;
    assign o_tex_start    = r_o_tstart;

    a_rows_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> r_o_row0 <= r_o_row1)
        else $error("draw start after draw end");

    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_h == 16'h0) |-> (r_o_step == 32'hFFFF_FFFF && r_o_tstart == 21'h0))
        else $error("zero height without saturated step");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> ({1'b0, r_o_col} < 9'(TEX_SIZE)))
        else $error("texture column out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

`default_nettype wire

FILE: tb/twcs_checker.sv
// column setup checker: predicts each accepted item and compares the strobed results
// depends on the textured_wall_column_setup port list only
`timescale 1ns / 100ps

module twcs_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [31:0] i_perp_dist,
    input  wire logic        i_hit_side,
    input  wire logic [31:0] i_ray_dir_x,
    input  wire logic [31:0] i_ray_dir_y,
    input  wire logic [31:0] i_player_x,
    input  wire logic [31:0] i_player_y,
    input  wire logic        o_valid,
    input  wire logic [15:0] o_slice_height,
    input  wire logic [8:0]  o_draw_start,
    input  wire logic [8:0]  o_draw_end,
    input  wire logic [4:0]  o_tex_column,
    input  wire logic [31:0] o_tex_step,
    input  wire logic [20:0] o_tex_start,
    output int               o_errors,
    output int               o_pending,
    output int               o_columns
);
    localparam int SCR_H = 480;
    localparam int TEX_W = 30;
    localparam int TEX_H = 30;

    typedef struct packed {
        logic [15:0] height;
        logic [8:0]  row_first;
        logic [8:0]  row_last;
        logic [4:0]  column;
        logic [31:0] step;
        logic [20:0] tex_pos;
    } t_column;

    t_column column_q[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h (column %0d)", what, got, want, o_columns);
        o_errors++;
    endtask

    function automatic t_column setup_column(input logic [31:0] hit_dist, input logic side,
            input logic [31:0] dx, input logic [31:0] dy,
            input logic [31:0] px, input logic [31:0] py);
        t_column c;
        logic [63:0] h, st, fr, col, sum, dir, pos;
        longint top, bot, off;
        if (hit_dist == 0) h = 65535;
        else begin
            h = (64'(SCR_H) << 16) / hit_dist;
            if (h > 65535) h = 65535;
        end
        top = SCR_H / 2 - longint'(h / 2);
        if (top < 0) top = 0;
        bot = SCR_H / 2 + longint'(h / 2);
        if (bot >= SCR_H) bot = SCR_H - 1;
        dir = side ? {{32{dx[31]}}, dx} : {{32{dy[31]}}, dy};
        pos = side ? 64'(px) : 64'(py);
        sum = (pos << 16) + 64'(hit_dist) * dir;
        fr  = sum & 64'hFFFF_FFFF;
        col = (fr * TEX_W) >> 32;
        if ((!side && !dx[31] && dx != 0) || (side && dy[31])) col = TEX_W - 1 - col;
        st = (h == 0) ? 64'hFFFF_FFFF : (64'(TEX_H) << 16) / h;
        off = top - SCR_H / 2 + longint'(h / 2);
        c.height    = h[15:0];
        c.row_first = 9'(top);
        c.row_last  = 9'(bot);
        c.column    = col[4:0];
        c.step      = st[31:0];
        c.tex_pos   = (h != 0 && off > 0) ? 21'(64'(off) * st) : '0;
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_column w;
        if (i_rst_n) begin
            if (start && !busy)
                column_q.push_back(setup_column(i_perp_dist, i_hit_side, i_ray_dir_x,
                                                i_ray_dir_y, i_player_x, i_player_y));
            if (o_valid) begin
                if (column_q.size() == 0) report("unexpected result", 0, 0);
                else begin
                    w = column_q.pop_front();
                    if (o_slice_height !== w.height) report("slice_height", o_slice_height, w.height);
                    if (o_draw_start !== w.row_first) report("draw_start", o_draw_start, w.row_first);
                    if (o_draw_end !== w.row_last) report("draw_end", o_draw_end, w.row_last);
                    if (o_tex_column !== w.column) report("tex_column", o_tex_column, w.column);
                    if (o_tex_step !== w.step) report("tex_step", o_tex_step, w.step);
                    if (o_tex_start !== w.tex_pos) report("tex_start", o_tex_start, w.tex_pos);
                    o_columns++;
                end
            end
        end
        o_pending = column_q.size();
    end

    initial begin
        o_errors  = 0;
        o_columns = 0;
        o_pending = 0;
    end
endmodule

FILE: tb/tb_top.sv
// column setup testbench top: clock, reset, directed and random ray hits, verdict
// depends on textured_wall_column_setup and twcs_checker
`timescale 1ns / 100ps

module tb_top;
    localparam int LATENCY = 43;
    localparam int LIMIT = 400000;

    logic        i_clk = 0, i_rst_n = 0, start = 0;
    logic        busy, o_valid;
    logic [31:0] i_perp_dist = 0, i_ray_dir_x = 0, i_ray_dir_y = 0;
    logic [31:0] i_player_x = 0, i_player_y = 0;
    logic        i_hit_side = 0;
    logic [15:0] o_slice_height;
    logic [8:0]  o_draw_start, o_draw_end;
    logic [4:0]  o_tex_column;
    logic [20:0] o_tex_start;
    logic [31:0] o_tex_step;
    int          errors, pending, columns, cycles = 0, idle_pct = 0, sent = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    textured_wall_column_setup dut (.*);
    twcs_checker chk (.*, .o_errors(errors), .o_pending(pending), .o_columns(columns));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout");
            $display("[textured_wall_column_setup] ERROR");
            $finish;
        end
    end

    // hold one item on the ports until it is taken
    task automatic send_hit(input logic [31:0] d, input logic s, input logic [31:0] dx,
            input logic [31:0] dy, input logic [31:0] px, input logic [31:0] py);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_perp_dist <= d; i_hit_side <= s; i_ray_dir_x <= dx;
        i_ray_dir_y <= dy; i_player_x <= px; i_player_y <= py;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [31:0] rand_dist();
        case ($urandom_range(5))
            0: return $urandom_range(3);
            1: return $urandom_range(32'h1000);
            2: return $urandom_range(32'h20_0000, 32'h1_0000);
            3: return 32'h1E0_0000 + $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        static logic [31:0] edges[6] = '{0, 1, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'hFFFF_FFFF, 32'h1_0000};
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;
        // extremes of every field, both sides, near and far walls
        for (int k = 0; k < 24; k++)
            send_hit(edges[k % 6], k[0], edges[(k + 1) % 6], edges[(k + 3) % 6],
                     edges[(k + 2) % 6], edges[(k + 5) % 6]);
        send_hit(32'h1E0_0000, 1'b0, 1, 0, 32'h8000, 32'h8000);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 84 : (ph == 3) ? 35 : 0;
            for (int n = 0; n < 400; n++)
                send_hit(rand_dist(), 1'($urandom_range(1)), $urandom, $urandom,
                         $urandom, $urandom);
        end
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("sent %0d ray hits, checked %0d columns, gaps on and off", sent, columns);
        if (errors == 0 && pending == 0) $display("[textured_wall_column_setup] OK");
        else $display("[textured_wall_column_setup] ERROR");
        $finish;
    end
endmodule
